// ===== rtl/mcf_pkg.sv =====
// ----------------------------------------------------------------------------
// mcf_pkg
// Shared types, constants and the byte-wise CRC-16 step for the motor
// command framer.
// ----------------------------------------------------------------------------
package mcf_pkg;

    // frame layout
    localparam logic [7:0]  START_BYTE = 8'hFF;
    localparam logic [7:0]  LEN_BYTE   = 8'h07;
    localparam logic [7:0]  PAD_BYTE   = 8'h00;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'hA001;

    // byte positions in the frame
    localparam int unsigned POS_W = 4;
    localparam logic [POS_W-1:0] POS_START   = 4'd0;
    localparam logic [POS_W-1:0] POS_LEN     = 4'd1;
    localparam logic [POS_W-1:0] POS_LEFT    = 4'd2;
    localparam logic [POS_W-1:0] POS_PAD_L   = 4'd3;
    localparam logic [POS_W-1:0] POS_RIGHT   = 4'd4;
    localparam logic [POS_W-1:0] POS_PAD_R   = 4'd5;
    localparam logic [POS_W-1:0] POS_FLAGS   = 4'd6;
    localparam logic [POS_W-1:0] POS_CRC_LO  = 4'd7;
    localparam logic [POS_W-1:0] POS_CRC_HI  = 4'd8;

    // crc pipeline: one frame byte per stage, left speed through flags
    localparam int unsigned NUM_STAGES = 5;
    localparam int unsigned STG_W      = 3;
    localparam logic [STG_W-1:0] STG_LEFT  = 3'd0;
    localparam logic [STG_W-1:0] STG_PAD_L = 3'd1;
    localparam logic [STG_W-1:0] STG_RIGHT = 3'd2;
    localparam logic [STG_W-1:0] STG_PAD_R = 3'd3;
    localparam logic [STG_W-1:0] STG_FLAGS = 3'd4;

    typedef struct packed {
        logic [7:0] left_speed;
        logic [7:0] right_speed;
        logic [7:0] direction_flags;
    } t_cmd;

    typedef struct packed {
        t_cmd        cmd;
        logic [15:0] crc;
    } t_frame;

    // reflected crc-16 update with one byte, lsb first
    function automatic logic [15:0] crc_add_byte(input logic [15:0] crc_in,
                                                 input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    // crc after the length byte is fixed
    localparam logic [15:0] CRC_AFTER_LEN = crc_add_byte(CRC_INIT, LEN_BYTE);

    // byte folded into the crc at a given pipeline stage
    function automatic logic [7:0] stage_byte(input logic [STG_W-1:0] stg,
                                              input t_cmd             cmd);
        logic [7:0] b;
        case (stg)
            STG_LEFT:  b = cmd.left_speed;
            STG_RIGHT: b = cmd.right_speed;
            STG_FLAGS: b = cmd.direction_flags;
            default:   b = PAD_BYTE;
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/motor_command_framer_crc16_unit.sv =====
// Path: each command passes the five crc stages and then the serializer's
// frame register before its first byte is valid; the bytes then follow in order.
// Rate: bounded by the single byte-wide output, which sends nine bytes a frame;
// the 5-stage crc pipeline takes a command every cycle while it has room.
// Reset: synchronous, active low; clears all stage valid bits and the byte
// counter, no frame is in flight afterwards.
// ----------------------------------------------------------------------------
// motor_command_framer_crc16_unit
// Turns each motor command into a nine-byte frame with a trailing CRC-16
// (reflected 0xA001, init 0xFFFF) over the length, speed, pad and flag bytes.
// ----------------------------------------------------------------------------
module motor_command_framer_crc16_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_left_speed,
    input  logic [7:0] i_right_speed,
    input  logic [7:0] i_direction_flags,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_frame_byte,
    output logic       o_end_of_frame
);
    import mcf_pkg::*;

    t_cmd   in_cmd;
    t_frame pipe_frame;
    logic   pipe_in_ready;
    logic   pipe_valid;
    logic   ser_ready;

    // pack the command fields
    assign in_cmd.left_speed      = i_left_speed;
    assign in_cmd.right_speed     = i_right_speed;
    assign in_cmd.direction_flags = i_direction_flags;

    // crc computation
    mcf_crc_pipe u_crc_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (pipe_in_ready),
        .i_cmd   (in_cmd),
        .o_valid (pipe_valid),
        .i_ready (ser_ready),
        .o_frame (pipe_frame)
    );

    // byte output
    mcf_serializer u_serializer (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (pipe_valid),
        .o_ready        (ser_ready),
        .i_frame        (pipe_frame),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_frame_byte   (o_frame_byte),
        .o_end_of_frame (o_end_of_frame)
    );

    assign o_stall = !pipe_in_ready;

endmodule

// ===== rtl/mcf_crc_pipe.sv =====
// ----------------------------------------------------------------------------
// mcf_crc_pipe
// Five-stage pipeline that folds one frame byte per stage into the CRC,
// with a valid bit per stage and per-stage ready for stalls.
// ----------------------------------------------------------------------------
module mcf_crc_pipe (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  mcf_pkg::t_cmd i_cmd,
    output logic          o_valid,
    input  logic          i_ready,
    output mcf_pkg::t_frame o_frame
);
    import mcf_pkg::*;

    logic                  r_valid [NUM_STAGES];
    t_frame                r_frame [NUM_STAGES];
    logic                  in_valid [NUM_STAGES];
    t_frame                in_frame [NUM_STAGES];
    t_frame                n_frame [NUM_STAGES];
    logic [NUM_STAGES:0]   stg_ready;

    // stage inputs
    always_comb begin
        in_valid[0]     = i_valid;
        in_frame[0].cmd = i_cmd;
        in_frame[0].crc = CRC_AFTER_LEN;
        for (int k = 1; k < NUM_STAGES; k++) begin
            in_valid[k] = r_valid[k-1];
            in_frame[k] = r_frame[k-1];
        end
    end

    // one crc byte per stage
    always_comb begin
        for (int k = 0; k < NUM_STAGES; k++) begin
            n_frame[k].cmd = in_frame[k].cmd;
            n_frame[k].crc = crc_add_byte(in_frame[k].crc,
                                          stage_byte(STG_W'(k), in_frame[k].cmd));
        end
    end

    // a stage takes new data when empty or when its content moves on
    always_comb begin
        stg_ready[NUM_STAGES] = i_ready;
        for (int k = NUM_STAGES - 1; k >= 0; k--) begin
            stg_ready[k] = !r_valid[k] || stg_ready[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NUM_STAGES; k++) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (stg_ready[k]) begin
                r_valid[k] <= in_valid[k];
            end
            if (stg_ready[k] && in_valid[k]) begin
                r_frame[k] <= n_frame[k];
            end
        end
    end

    assign o_ready = stg_ready[0];
    assign o_valid = r_valid[NUM_STAGES-1];
    assign o_frame = r_frame[NUM_STAGES-1];

`ifndef ASSERT_OFF
    // last stage holds its item while the serializer is busy
    a_hold_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid[NUM_STAGES-1] && !i_ready) |=>
            (r_valid[NUM_STAGES-1] && $stable(r_frame[NUM_STAGES-1])))
        else $error("crc pipe dropped or changed a stalled item");
    // a full first stage that cannot move blocks the input
    a_block_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid[0] && !stg_ready[1]) |-> !o_ready)
        else $error("crc pipe accepted into a blocked stage");
`endif

endmodule

// ===== rtl/mcf_serializer.sv =====
// ----------------------------------------------------------------------------
// mcf_serializer
// Holds one finished frame and sends its nine bytes one per transfer,
// loading the next frame in the same cycle as the last byte goes out.
// ----------------------------------------------------------------------------
module mcf_serializer (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  mcf_pkg::t_frame i_frame,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [7:0]      o_frame_byte,
    output logic            o_end_of_frame
);
    import mcf_pkg::*;

    logic             r_busy;
    logic [POS_W-1:0] r_pos;
    t_frame           r_frame;
    logic             last_xfer;

    assign last_xfer = r_busy && !i_stall && (r_pos == POS_CRC_HI);
    assign o_ready   = !r_busy || last_xfer;

    // byte counter and frame hold
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pos  <= POS_START;
        end else if (o_ready) begin
            r_busy <= i_valid;
            r_pos  <= POS_START;
        end else if (!i_stall) begin
            r_pos <= r_pos + POS_W'(1);
        end
        if (o_ready && i_valid) begin
            r_frame <= i_frame;
        end
    end

    // byte select
    always_comb begin
        case (r_pos)
            POS_START:  o_frame_byte = START_BYTE;
            POS_LEN:    o_frame_byte = LEN_BYTE;
            POS_LEFT:   o_frame_byte = r_frame.cmd.left_speed;
            POS_RIGHT:  o_frame_byte = r_frame.cmd.right_speed;
            POS_FLAGS:  o_frame_byte = r_frame.cmd.direction_flags;
            POS_CRC_LO: o_frame_byte = r_frame.crc[7:0];
            POS_CRC_HI: o_frame_byte = r_frame.crc[15:8];
            default:    o_frame_byte = PAD_BYTE;
        endcase
    end

    assign o_valid        = r_busy;
    assign o_end_of_frame = (r_pos == POS_CRC_HI);

`ifndef ASSERT_OFF
    // counter rests at the start byte while idle
    a_idle_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_pos == POS_START))
        else $error("byte counter not at start while idle");
    // counter never runs past the last byte
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_CRC_HI)
        else $error("byte counter out of range");
    // a stalled byte keeps its place
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && i_stall) |=> (r_busy && $stable(r_pos)))
        else $error("byte counter moved during stall");
    // after the last byte goes out the counter is back at the start
    a_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        last_xfer |=> (r_pos == POS_START))
        else $error("byte counter did not wrap after frame end");
`endif

endmodule
